// File: hdl/cpes_pkg.sv
// cpes_pkg: shared types, defaults and tables for the cart-pole step unit
// depends on nothing; used by cart_pole_euler_step_unit
package cpes_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int CORDIC_ITER_DEF = 24;

    localparam int S_DATA_W = 144;
    localparam int M_DATA_W = 120;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORCE_MAG = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_EN = 8'd3;

    localparam logic [30:0] GRAVITY_RST = 31'd164416307;
    localparam logic [30:0] FORCE_MAG_RST = 31'd167772160;
    localparam logic [24:0] TIME_STEP_RST = 25'd335544;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_WRAP   = 6'b000010,
        S_CORDIC = 6'b000100,
        S_MUL    = 6'b001000,
        S_DIV    = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    typedef enum logic [4:0] {
        ST_NOISE = 5'd0,
        ST_W1    = 5'd1,
        ST_W2    = 5'd2,
        ST_TEMP0 = 5'd3,
        ST_TEMP1 = 5'd4,
        ST_GSN   = 5'd5,
        ST_NUM   = 5'd6,
        ST_CC    = 5'd7,
        ST_DEN0  = 5'd8,
        ST_DEN1  = 5'd9,
        ST_X0    = 5'd10,
        ST_X1    = 5'd11,
        ST_XACC  = 5'd12,
        ST_POS   = 5'd13,
        ST_CVEL  = 5'd14,
        ST_ANG   = 5'd15,
        ST_PVEL  = 5'd16
    } t_step;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        unique case (i)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh07fffffff) r = 32'sh7fffffff;
        else if (v < -34'sh080000000) r = -32'sh80000000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [33:0] v,
                                                   input logic signed [31:0] lim);
        logic signed [31:0] r;
        if (v > 34'(lim)) r = lim;
        else if (v < -34'(lim)) r = -lim;
        else r = v[31:0];
        return r;
    endfunction

endpackage

// File: hdl/cart_pole_euler_step_unit.sv
// cart_pole_euler_step_unit: cart-pole Euler step on one shared multiplier,
// a cordic, a restoring divider and an angle wrap, under one sequencer
// depends on cpes_pkg
//
// input stream: tuser is the kind (0 step, 1 load); tdata carries the action,
// the noise sample and the four load values. one item in flight at a time:
// tready is high only while the sequencer is idle.
// output stream: one item per input item with the new state and reward in
// tdata; tlast is the terminal flag.
// config channel: register index and data, always ready; the user must write it only
// when idle, and the block has no check for it. a load item passes through S_OUT
// into the output register. a step item runs the angle wrap, the cordic, the 17
// products on the single multiplier with the restoring divider after the
// denominator product, and a final angle wrap; each angle wrap takes one more
// turn for each extra multiple of two pi that it must remove.
// the next item is taken while a finished item waits in the output register;
// if the receiver stalls, the following item holds until that register frees.
// reset (synchronous, active low) clears the state to zero, loads the default
// register values and drops the output valid.
module cart_pole_euler_step_unit #(
    parameter int FRAC_BITS = cpes_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_ITERATIONS = cpes_pkg::CORDIC_ITER_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // push_right, noise_sample, load_cart_position, load_cart_velocity,
    // load_pole_angle, load_pole_velocity
    input  logic [cpes_pkg::S_DATA_W-1:0]    i_s_axis_tdata,
    // kind
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // cart_position, cart_velocity, pole_angle, pole_velocity, reward
    output logic [cpes_pkg::M_DATA_W-1:0]    o_m_axis_tdata,
    output logic                             o_m_axis_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cpes_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cpes_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cpes_pkg::*;

    localparam longint ONE_Q = longint'(1) << FRAC_BITS;
    localparam longint PI_L = (64'sd3141592654 * ONE_Q + 64'sd500000000) / 64'sd1000000000;
    localparam longint TWO_PI_L = (64'sd6283185307 * ONE_Q + 64'sd500000000) / 64'sd1000000000;
    localparam longint HALF_PI_L = (64'sd1570796327 * ONE_Q + 64'sd500000000) / 64'sd1000000000;
    localparam longint PML_L = (ONE_Q + 10) / 20;
    localparam longint INV_TM_L = (10 * ONE_Q + 5) / 11;
    localparam longint MP_TM_L = (ONE_Q + 5) / 11;
    localparam longint LEN_L = (ONE_Q + 1) / 2;
    localparam longint FT_L = (4 * ONE_Q + 1) / 3;
    localparam longint ANG_LIM_L = (64'sd20943948 * ONE_Q + 64'sd50000000) / 64'sd100000000;
    localparam longint POS_LIM_L = (12 * ONE_Q + 2) / 5;
    localparam longint GAIN_L = (64'sd607252935 * ONE_Q + 64'sd500000000) / 64'sd1000000000;

    localparam logic signed [31:0] PI_Q = 32'(PI_L);
    localparam logic signed [33:0] PI_W = 34'(PI_L);
    localparam logic signed [33:0] TWO_PI_W = 34'(TWO_PI_L);
    localparam logic signed [33:0] HALF_PI_W = 34'(HALF_PI_L);
    localparam logic signed [31:0] PML_Q = 32'(PML_L);
    localparam logic signed [31:0] INV_TM_Q = 32'(INV_TM_L);
    localparam logic signed [31:0] MP_TM_Q = 32'(MP_TM_L);
    localparam logic signed [31:0] LEN_Q = 32'(LEN_L);
    localparam logic signed [31:0] FT_Q = 32'(FT_L);
    localparam logic signed [31:0] VEL_LIM_Q = 32'(3 * ONE_Q);
    localparam logic signed [31:0] ANG_LIM_Q = 32'(ANG_LIM_L);
    localparam logic signed [32:0] POS_LIM_Q = 33'(POS_LIM_L);
    localparam logic signed [33:0] GAIN_Q = 34'(GAIN_L);
    localparam logic signed [63:0] HALF_Q = 64'(ONE_Q >> 1);
    localparam logic [30:0] ATAN_RND = 31'(longint'(1) << (29 - FRAC_BITS));

    localparam int DW = 32 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    t_state r_state;
    t_step  r_step;
    logic   r_ph;
    logic   r_final;
    logic   r_flip;
    logic [CW-1:0] r_cnt;

    logic [30:0] r_gravity;
    logic [30:0] r_force_mag;
    logic [24:0] r_time_step;
    logic        r_noise_en;

    logic signed [31:0] r_cp, r_cv, r_pa, r_pv;
    logic signed [31:0] r_sn, r_cs, r_force, r_p, r_t, r_num, r_den, r_tacc, r_xacc;
    logic signed [24:0] r_noise;
    logic signed [33:0] r_ang, r_x, r_y, r_z;
    logic signed [63:0] r_prod;
    logic [DW-1:0] r_dvd;
    logic [31:0]   r_rem;
    logic          r_neg;

    logic                r_o_valid;
    logic [M_DATA_W-1:0] r_o_data;
    logic                r_o_last;

    logic signed [31:0] w_a, w_b, w_m;
    logic signed [63:0] w_rnd;
    logic signed [31:0] w_fm, w_gr, w_ts;
    logic [30:0] w_atan;
    logic signed [33:0] w_xs, w_ys;
    logic [32:0] w_rt;
    logic        w_ge;
    logic [DW-1:0] w_q;
    logic signed [31:0] w_qsat;
    logic [31:0] w_num_abs;
    logic [31:0] w_pa_abs;
    logic [32:0] w_cp_abs;
    logic        w_term;
    logic        w_s_acc;
    logic        w_out_free;

    assign w_fm = signed'({1'b0, r_force_mag});
    assign w_gr = signed'({1'b0, r_gravity});
    assign w_ts = signed'({7'd0, r_time_step});

    // operand select per sequencer step
    always_comb begin
        unique case (r_step)
            ST_NOISE: begin w_a = w_fm;     w_b = 32'(r_noise); end
            ST_W1:    begin w_a = PML_Q;    w_b = r_pv;         end
            ST_W2:    begin w_a = r_p;      w_b = r_pv;         end
            ST_TEMP0: begin w_a = r_p;      w_b = r_sn;         end
            ST_TEMP1: begin w_a = r_p;      w_b = INV_TM_Q;     end
            ST_GSN:   begin w_a = w_gr;     w_b = r_sn;         end
            ST_NUM:   begin w_a = r_cs;     w_b = r_t;          end
            ST_CC:    begin w_a = r_cs;     w_b = r_cs;         end
            ST_DEN0:  begin w_a = r_p;      w_b = MP_TM_Q;      end
            ST_DEN1:  begin w_a = LEN_Q;    w_b = r_p;          end
            ST_X0:    begin w_a = PML_Q;    w_b = r_tacc;       end
            ST_X1:    begin w_a = r_p;      w_b = r_cs;         end
            ST_XACC:  begin w_a = r_p;      w_b = INV_TM_Q;     end
            ST_POS:   begin w_a = w_ts;     w_b = r_cv;         end
            ST_CVEL:  begin w_a = w_ts;     w_b = r_xacc;       end
            ST_ANG:   begin w_a = w_ts;     w_b = r_pv;         end
            ST_PVEL:  begin w_a = w_ts;     w_b = r_tacc;       end
            default:  begin w_a = '0;       w_b = '0;           end
        endcase
    end

    always_comb begin
        w_rnd = (r_prod + HALF_Q) >>> FRAC_BITS;
        if (w_rnd > 64'sh7fffffff) w_m = 32'sh7fffffff;
        else if (w_rnd < -64'sh80000000) w_m = -32'sh80000000;
        else w_m = w_rnd[31:0];
    end

    // cordic rotation
    assign w_atan = (31'(atan_q30(r_cnt[4:0])) + ATAN_RND) >> (30 - FRAC_BITS);
    assign w_xs = r_x >>> r_cnt[4:0];
    assign w_ys = r_y >>> r_cnt[4:0];

    // restoring divider step
    assign w_rt = {r_rem, r_dvd[DW-1]};
    assign w_ge = (w_rt >= {1'b0, r_den[31:0]});
    assign w_q = r_dvd;
    always_comb begin
        if (r_den <= 32'sd0) begin
            w_qsat = r_neg ? -32'sh80000000 : 32'sh7fffffff;
        end else if (!r_neg) begin
            w_qsat = (w_q > DW'(32'h7fffffff)) ? 32'sh7fffffff : signed'(w_q[31:0]);
        end else begin
            w_qsat = (w_q > DW'(33'h080000000)) ? -32'sh80000000 : -signed'(w_q[31:0]);
        end
    end
    assign w_num_abs = r_num[31] ? 32'(-33'(r_num)) : r_num[31:0];

    assign w_pa_abs = r_pa[31] ? 32'(-33'(r_pa)) : r_pa[31:0];
    assign w_cp_abs = r_cp[31] ? 33'(-33'(r_cp)) : 33'(r_cp);
    assign w_term = (w_pa_abs > ANG_LIM_Q[31:0]) || (w_cp_abs > POS_LIM_Q[32:0]);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_o_valid || i_m_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata = r_o_data;
    assign o_m_axis_tlast = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step <= ST_NOISE;
            r_ph <= 1'b0;
            r_final <= 1'b0;
            r_cnt <= '0;
            r_o_valid <= 1'b0;
            r_gravity <= GRAVITY_RST;
            r_force_mag <= FORCE_MAG_RST;
            r_time_step <= TIME_STEP_RST;
            r_noise_en <= 1'b0;
            r_cp <= '0;
            r_cv <= '0;
            r_pa <= '0;
            r_pv <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_GRAVITY:   r_gravity <= i_cfg_data[30:0];
                    CFG_FORCE_MAG: r_force_mag <= i_cfg_data[30:0];
                    CFG_TIME_STEP: r_time_step <= i_cfg_data[24:0];
                    CFG_NOISE_EN:  r_noise_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (r_state == S_OUT && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_m_axis_tready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        if (i_s_axis_tuser) begin
                            r_cp <= signed'(i_s_axis_tdata[57:26]);
                            r_cv <= 32'(signed'(i_s_axis_tdata[84:58]));
                            r_pa <= 32'(signed'(i_s_axis_tdata[111:85]));
                            r_pv <= 32'(signed'(i_s_axis_tdata[138:112]));
                            r_state <= S_OUT;
                        end else begin
                            r_force <= i_s_axis_tdata[0] ? w_fm : -w_fm;
                            r_noise <= signed'(i_s_axis_tdata[25:1]);
                            r_ang <= 34'(r_pa);
                            r_final <= 1'b0;
                            r_state <= S_WRAP;
                        end
                    end
                end
                S_WRAP: begin
                    if (r_ang >= PI_W) begin
                        r_ang <= r_ang - TWO_PI_W;
                    end else if (r_ang < -PI_W) begin
                        r_ang <= r_ang + TWO_PI_W;
                    end else if (r_final) begin
                        r_pa <= r_ang[31:0];
                        r_state <= S_OUT;
                    end else begin
                        // fold into the cordic range
                        if (r_ang > HALF_PI_W) begin
                            r_z <= r_ang - PI_W;
                            r_flip <= 1'b1;
                        end else if (r_ang < -HALF_PI_W) begin
                            r_z <= r_ang + PI_W;
                            r_flip <= 1'b1;
                        end else begin
                            r_z <= r_ang;
                            r_flip <= 1'b0;
                        end
                        r_x <= GAIN_Q;
                        r_y <= '0;
                        r_cnt <= '0;
                        r_state <= S_CORDIC;
                    end
                end
                S_CORDIC: begin
                    if (r_cnt == CW'(CORDIC_ITERATIONS)) begin
                        r_sn <= r_flip ? -r_y[31:0] : r_y[31:0];
                        r_cs <= r_flip ? -r_x[31:0] : r_x[31:0];
                        r_step <= ST_NOISE;
                        r_ph <= 1'b0;
                        r_state <= S_MUL;
                    end else begin
                        if (r_z >= 34'sd0) begin
                            r_x <= r_x - w_ys;
                            r_y <= r_y + w_xs;
                            r_z <= r_z - 34'(w_atan);
                        end else begin
                            r_x <= r_x + w_ys;
                            r_y <= r_y - w_xs;
                            r_z <= r_z + 34'(w_atan);
                        end
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MUL: begin
                    if (!r_ph) begin
                        r_prod <= w_a * w_b;
                        r_ph <= 1'b1;
                    end else begin
                        r_ph <= 1'b0;
                        r_step <= t_step'(r_step + 5'd1);
                        unique case (r_step)
                            ST_NOISE: if (r_noise_en) r_force <= sat32(34'(r_force) + 34'(w_m));
                            ST_W1, ST_W2, ST_GSN, ST_CC, ST_X0, ST_X1: r_p <= w_m;
                            ST_TEMP0: r_p <= sat32(34'(r_force) + 34'(w_m));
                            ST_TEMP1: r_t <= w_m;
                            ST_NUM:   r_num <= sat32(34'(r_p) - 34'(w_m));
                            ST_DEN0:  r_p <= sat32(34'(FT_Q) - 34'(w_m));
                            ST_DEN1: begin
                                r_den <= w_m;
                                r_dvd <= DW'(w_num_abs) << FRAC_BITS;
                                r_neg <= r_num[31];
                                r_rem <= '0;
                                r_cnt <= '0;
                                r_state <= S_DIV;
                            end
                            ST_XACC: r_xacc <= sat32(34'(r_t) - 34'(w_m));
                            ST_POS:  r_cp <= sat32(34'(r_cp) + 34'(w_m));
                            ST_CVEL: r_cv <= clamp32(34'(r_cv) + 34'(w_m), VEL_LIM_Q);
                            ST_ANG:  r_ang <= 34'(r_pa) + 34'(w_m);
                            ST_PVEL: begin
                                r_pv <= clamp32(34'(r_pv) + 34'(w_m), PI_Q);
                                r_final <= 1'b1;
                                r_state <= S_WRAP;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    if (r_cnt == CW'(DW)) begin
                        r_tacc <= w_qsat;
                        r_state <= S_MUL;
                    end else begin
                        r_rem <= w_ge ? 32'(w_rt - {1'b0, r_den[31:0]}) : w_rt[31:0];
                        r_dvd <= {r_dvd[DW-2:0], w_ge};
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_o_data <= {6'd0, !w_term, r_pv[26:0], r_pa[26:0], r_cv[26:0],
                                     r_cp[31:0]};
                        r_o_last <= w_term;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
